/* rtl/dsa_pkg.sv */
// Shared types and constants for the dual stack block.
package dsa_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int CAP_W  = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // Operation codes carried by the input item.
    localparam logic [OP_W-1:0] OP_PUSH_ONE = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TWO = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_ONE  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_TWO  = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // Register index taken from the byte address.
    localparam logic CFG_IDX_CAPACITY = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

/* rtl/dsa_if.sv */
// Valid/ready channel interfaces for the input and result items.
interface dsa_in_if import dsa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dsa_out_if import dsa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pop_value;
    logic [ST_W-1:0]          status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink   (input valid, input pop_value, input status, output ready);
endinterface

/* rtl/dsa_ram.sv */
// Generic single-port RAM with registered read data.
module dsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dsa_ctrl.sv */
// Sequencing state machine for the dual stack block.
module dsa_ctrl import dsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.take_in = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_HOLD;
            end
            S_HOLD: begin
                // The result moves on once the output register is free or emptying.
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");

    a_exec_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_HOLD))
        else $error("execution step did not reach the hold state");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.take_in, cmd.exec, cmd.load_out}))
        else $error("more than one datapath command in a cycle");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

/* rtl/dsa_dp.sv */
// Datapath: stack counts, shared store and result registers.
module dsa_dp import dsa_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic                     i_cfg_clear,
    input  logic [CAP_W-1:0]         i_capacity,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic signed [DATA_W-1:0] o_pop_value,
    output logic [ST_W-1:0]          o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > CAP_W) ? CW : CAP_W;

    logic [OP_W-1:0]          r_op;
    logic [DATA_W-1:0]        r_val;
    logic [CW-1:0]            r_lower;
    logic [CW-1:0]            n_lower;
    logic [CW-1:0]            r_upper;
    logic [CW-1:0]            n_upper;
    logic [ST_W-1:0]          r_status;
    logic [ST_W-1:0]          n_status;
    logic                     r_from_ram;
    logic                     n_from_ram;
    logic signed [DATA_W-1:0] r_pop_value;
    logic [ST_W-1:0]          r_status_out;

    logic [WW-1:0]     cap_ext;
    logic [WW-1:0]     depth_ext;
    logic [CW-1:0]     cap;
    logic [CW:0]       used;
    logic              full;
    logic [CW-1:0]     addr_full;
    logic              ram_en;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] result;

    // Effective capacity saturates at the store depth.
    always_comb begin
        cap_ext   = WW'(i_capacity);
        depth_ext = WW'(DEPTH);
        cap       = (cap_ext > depth_ext) ? CW'(depth_ext) : CW'(cap_ext);
        used      = {1'b0, r_lower} + {1'b0, r_upper};
        full      = (used >= {1'b0, cap});
    end

    always_comb begin
        n_lower    = r_lower;
        n_upper    = r_upper;
        n_status   = ST_OK;
        n_from_ram = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        addr_full  = r_lower;
        case (r_op)
            OP_PUSH_ONE: begin
                addr_full = r_lower;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_en  = 1'b1;
                    ram_we  = 1'b1;
                    n_lower = r_lower + CW'(1);
                end
            end
            OP_PUSH_TWO: begin
                addr_full = cap - r_upper - CW'(1);
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_en  = 1'b1;
                    ram_we  = 1'b1;
                    n_upper = r_upper + CW'(1);
                end
            end
            OP_POP_ONE: begin
                addr_full = r_lower - CW'(1);
                if (r_lower == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_en     = 1'b1;
                    n_from_ram = 1'b1;
                    n_lower    = r_lower - CW'(1);
                end
            end
            OP_POP_TWO: begin
                addr_full = cap - r_upper;
                if (r_upper == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    ram_en     = 1'b1;
                    n_from_ram = 1'b1;
                    n_upper    = r_upper - CW'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    dsa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en && i_cmd.exec),
        .i_we    (ram_we),
        .i_addr  (addr_full[AW-1:0]),
        .i_wdata (r_val),
        .o_rdata (ram_rdata)
    );

    // A failed pop answers all ones; a push answers zero.
    always_comb begin
        if (r_from_ram) begin
            result = ram_rdata;
        end else if (r_status == ST_EMPTY) begin
            result = '1;
        end else begin
            result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
        end else if (i_cfg_clear) begin
            r_lower <= '0;
            r_upper <= '0;
        end else if (i_cmd.exec) begin
            r_lower <= n_lower;
            r_upper <= n_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_from_ram <= n_from_ram;
        end
        if (i_cmd.load_out) begin
            r_pop_value  <= result;
            r_status_out <= r_status;
        end
    end

    assign o_pop_value = r_pop_value;
    assign o_status    = r_status_out;

endmodule

/* rtl/dual_stack_shared_array.sv */
// Top level: two stacks in one shared store, with an APB capacity register.
//
// Usage: input items arrive on i_in (opcode, push_value) and each gives
// exactly one result item on o_out (pop_value, status), in order. Opcode 0
// pushes stack one, which grows up from entry 0; opcode 1 pushes stack two,
// which grows down from the top of the used capacity; opcodes 2 and 3 pop
// them. A push into a full store is dropped with status 1 and pop_value 0;
// a pop from an empty stack returns all ones with status 2.
// Timing: an item is accepted in the idle state, executes against the store
// in the next cycle, and its result is loaded into the output register from
// the hold state. A new item is accepted only once that result is loaded.
// This order comes from the single-port store, which is accessed and then
// has its read data registered.
// If the receiver stalls, the finished result waits in the output register;
// the block still takes one more item and parks its result in the datapath
// until the output register frees, and only then accepts again.
// Reset clears both stack counts and sets capacity to 1024; the store is
// not cleared. Writing capacity over APB (byte address 0) empties both
// stacks; the user does it only while the block is idle (not enforced).
module dual_stack_shared_array import dsa_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dsa_in_if.sink              i_in,
    dsa_out_if.source           o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             cap_sel;
    logic             cfg_write;
    t_cmd             cmd;

    // Register index is the word address; only index zero exists.
    assign cap_sel   = (paddr[2] == CFG_IDX_CAPACITY);
    assign cfg_write = psel && penable && pwrite && cap_sel;
    assign pready    = 1'b1;
    assign prdata    = cap_sel ? DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_write) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    dsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    dsa_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_clear  (cfg_write),
        .i_capacity   (r_capacity),
        .i_opcode     (i_in.opcode),
        .i_push_value (i_in.push_value),
        .o_pop_value  (o_out.pop_value),
        .o_status     (o_out.status)
    );

endmodule
